// ===== sv/ymfr_pkg.sv =====
// Package for the Ymodem file receiver core: codes, protocol characters,
// enum types and the per-result record shared by front, queue and back.
// No dependencies.
`default_nettype none
package ymfr_pkg;

  // Default sizing
  localparam int ADDR_WIDTH_DEF  = 20;
  localparam int SIZE_DIGITS_DEF = 16;
  localparam int NAME_LIMIT_DEF  = 64;
  localparam int QUEUE_DEPTH     = 4;

  // Protocol characters
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] SEQ_CMPL = 8'hff;

  localparam logic [10:0] HEADER_LEN  = 11'd133;
  localparam logic [10:0] POS_MAX     = 11'd2047;
  localparam logic [10:0] HDR_PAYLOAD = 11'd128;
  localparam logic [10:0] SOH_PAYLOAD = 11'd128;
  localparam logic [10:0] STX_PAYLOAD = 11'd1024;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TX    = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_SOH  = 2'd1,
    PK_STX  = 2'd2,
    PK_EOT  = 2'd3
  } pkt_e;

  typedef enum logic [1:0] {
    HF_NAME = 2'd0,
    HF_SKIP = 2'd1,
    HF_SIZE = 2'd2,
    HF_DONE = 2'd3
  } field_e;

  // One result without its address and file length
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Queue flags seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== sv/ymfr_fifo.sv =====
// Short queue of step records between the front and the back of the
// Ymodem receiver. Depends on ymfr_pkg for the status struct.
`default_nettype none
module ymfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ymfr_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [WIDTH-1:0]    data_i,
  input  wire logic                pop_i,
  output logic [WIDTH-1:0]         data_o,
  output ymfr_pkg::q_stat_t        stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ymfr_front.sv =====
// Front of the Ymodem receiver: accepts items, runs the session state and
// packs the results of each step into one queue record. Depends on ymfr_pkg.
`default_nettype none
module ymfr_front #(
  parameter int ADDR_WIDTH  = ymfr_pkg::ADDR_WIDTH_DEF,
  parameter int SIZE_DIGITS = ymfr_pkg::SIZE_DIGITS_DEF,
  parameter int NAME_LIMIT  = ymfr_pkg::NAME_LIMIT_DEF,
  parameter int ENTRY_W     = 2 * ymfr_pkg::RES_W + 2 * ADDR_WIDTH + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 burst_end_i,
  input  wire ymfr_pkg::q_stat_t    q_stat_i,
  output logic                      push_o,
  output logic [ENTRY_W-1:0]        entry_o
);

  localparam int LW = ADDR_WIDTH + 1;
  localparam int PW = ADDR_WIDTH + 5;
  localparam int DW = $clog2(SIZE_DIGITS + 1);
  localparam logic [LW-1:0] MEM_SIZE = {1'b1, {ADDR_WIDTH{1'b0}}};
  localparam logic [DW-1:0] DIG_LIM  = DW'(SIZE_DIGITS);
  localparam logic [8:0]    NAME_LIM = 9'(NAME_LIMIT);

  ymfr_pkg::phase_e phase_q, phase_d;
  ymfr_pkg::pkt_e   pkt_q, pkt_d;
  ymfr_pkg::field_e field_q, field_d;
  logic [10:0]      pos_q, pos_d;
  logic [7:0]       seq_q, seq_d;
  logic             seq_bad_q, seq_bad_d;
  logic             end_pend_q, end_pend_d;
  logic [DW-1:0]    digits_q, digits_d;
  logic [LW-1:0]    size_q, size_d;
  logic [LW-1:0]    wcount_q, wcount_d;
  logic             hdr_empty_q, hdr_empty_d;

  logic             accept;
  logic [1:0]       n_res;
  ymfr_pkg::res_t   r0, r1;
  logic [ADDR_WIDTH-1:0] addr;
  logic [10:0]      d;
  logic [10:0]      pos_inc;
  logic [10:0]      limit;
  logic [PW-1:0]    prod;
  logic             wr;

  assign ready_o = !q_stat_i.full;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && (n_res != 2'd0);
  assign entry_o = {size_d, addr, r1, r0, n_res[1]};

  assign d       = pos_q - 11'd3;
  assign pos_inc = (pos_q < ymfr_pkg::POS_MAX) ? pos_q + 11'd1 : pos_q;
  assign limit   = (pkt_q == ymfr_pkg::PK_SOH) ? ymfr_pkg::SOH_PAYLOAD
                                               : ymfr_pkg::STX_PAYLOAD;
  // size * 10 + digit, as shifts and adds
  assign prod = ({4'b0000, size_q} << 3) + ({4'b0000, size_q} << 1)
              + PW'(byte_i - ymfr_pkg::CH_ZERO);

  always_comb begin
    phase_d     = phase_q;
    pkt_d       = pkt_q;
    field_d     = field_q;
    pos_d       = pos_q;
    seq_d       = seq_q;
    seq_bad_d   = seq_bad_q;
    end_pend_d  = end_pend_q;
    digits_d    = digits_q;
    size_d      = size_q;
    wcount_d    = wcount_q;
    hdr_empty_d = hdr_empty_q;
    n_res       = 2'd0;
    r0          = '{kind: ymfr_pkg::KIND_WRITE, data: 8'h00, status: ymfr_pkg::ST_OK};
    r1          = '{kind: ymfr_pkg::KIND_WRITE, data: 8'h00, status: ymfr_pkg::ST_OK};
    addr        = '0;
    wr          = 1'b0;

    case (ymfr_pkg::op_e'(op_i))
      ymfr_pkg::OP_START: begin
        pos_d       = '0;
        pkt_d       = ymfr_pkg::PK_NONE;
        seq_d       = '0;
        seq_bad_d   = 1'b0;
        end_pend_d  = 1'b0;
        field_d     = ymfr_pkg::HF_NAME;
        digits_d    = '0;
        size_d      = '0;
        wcount_d    = '0;
        hdr_empty_d = 1'b1;
        phase_d     = ymfr_pkg::PH_HEADER;
        r0.kind     = ymfr_pkg::KIND_TX;
        r0.data     = ymfr_pkg::CH_C;
        n_res       = 2'd1;
      end
      ymfr_pkg::OP_TIMEOUT: begin
        if (phase_q == ymfr_pkg::PH_HEADER) begin
          r0.kind   = ymfr_pkg::KIND_END;
          r0.status = (pos_q != '0) ? ymfr_pkg::ST_BAD : ymfr_pkg::ST_TIMEOUT;
          n_res     = 2'd1;
        end else if (phase_q == ymfr_pkg::PH_DATA) begin
          r0.kind   = ymfr_pkg::KIND_END;
          n_res     = 2'd1;
        end
        phase_d = ymfr_pkg::PH_IDLE;
        pos_d   = '0;
      end
      ymfr_pkg::OP_BYTE: begin
        if (phase_q != ymfr_pkg::PH_IDLE) begin
          // per-byte packet decode
          if (pos_q == 11'd0) begin
            case (byte_i)
              ymfr_pkg::CH_SOH: pkt_d = ymfr_pkg::PK_SOH;
              ymfr_pkg::CH_STX: pkt_d = ymfr_pkg::PK_STX;
              ymfr_pkg::CH_EOT: pkt_d = ymfr_pkg::PK_EOT;
              default:          pkt_d = ymfr_pkg::PK_NONE;
            endcase
            seq_bad_d = 1'b1;
          end else if (pos_q == 11'd1) begin
            seq_d = byte_i;
          end else if (pos_q == 11'd2) begin
            seq_bad_d = ((seq_q ^ byte_i) != ymfr_pkg::SEQ_CMPL);
          end else if (phase_q == ymfr_pkg::PH_HEADER) begin
            if (d < ymfr_pkg::HDR_PAYLOAD) begin
              if (d == 11'd0) begin
                hdr_empty_d = (byte_i == 8'h00);
              end
              case (field_q)
                ymfr_pkg::HF_NAME: begin
                  if (byte_i == 8'h00) begin
                    field_d = ymfr_pkg::HF_SIZE;
                  end else if ({2'b00, d[6:0]} + 9'd1 >= NAME_LIM) begin
                    field_d = ymfr_pkg::HF_SKIP;
                  end
                end
                ymfr_pkg::HF_SKIP: field_d = ymfr_pkg::HF_SIZE;
                ymfr_pkg::HF_SIZE: begin
                  if (byte_i >= ymfr_pkg::CH_ZERO && byte_i <= ymfr_pkg::CH_NINE) begin
                    size_d   = (prod > {4'b0000, MEM_SIZE}) ? MEM_SIZE : prod[LW-1:0];
                    digits_d = digits_q + DW'(1);
                    if (digits_q + DW'(1) >= DIG_LIM) begin
                      field_d = ymfr_pkg::HF_DONE;
                    end
                  end else begin
                    field_d = ymfr_pkg::HF_DONE;
                  end
                end
                default: ;
              endcase
            end
          end else begin
            if ((pkt_q == ymfr_pkg::PK_SOH || pkt_q == ymfr_pkg::PK_STX) &&
                !end_pend_q && !seq_bad_q && d < limit && wcount_q < size_q) begin
              wr       = 1'b1;
              r0.kind  = ymfr_pkg::KIND_WRITE;
              r0.data  = byte_i;
              addr     = wcount_q[ADDR_WIDTH-1:0];
              n_res    = 2'd1;
              wcount_d = wcount_q + LW'(1);
            end
          end
          pos_d = pos_inc;

          // end of burst: answer the packet
          if (burst_end_i) begin
            if (phase_q == ymfr_pkg::PH_HEADER) begin
              if (pos_inc != ymfr_pkg::HEADER_LEN || seq_bad_d) begin
                r0.kind   = ymfr_pkg::KIND_END;
                r0.status = ymfr_pkg::ST_BAD;
                n_res     = 2'd1;
                phase_d   = ymfr_pkg::PH_IDLE;
              end else begin
                if (hdr_empty_d) begin
                  size_d = '0;
                end
                r0.kind = ymfr_pkg::KIND_TX;
                r0.data = ymfr_pkg::CH_ACK;
                r1.kind = ymfr_pkg::KIND_TX;
                r1.data = ymfr_pkg::CH_C;
                n_res   = hdr_empty_d ? 2'd1 : 2'd2;
                wcount_d   = '0;
                end_pend_d = 1'b0;
                phase_d    = ymfr_pkg::PH_DATA;
              end
            end else if (pkt_d == ymfr_pkg::PK_SOH || pkt_d == ymfr_pkg::PK_STX) begin
              // a write of this byte, if any, takes the first slot
              if (wr) begin
                n_res = 2'd2;
                r1.kind = ymfr_pkg::KIND_TX;
                r1.data = ymfr_pkg::CH_ACK;
              end else begin
                n_res = 2'd1;
                r0.kind = ymfr_pkg::KIND_TX;
                r0.data = ymfr_pkg::CH_ACK;
              end
              if (end_pend_q) begin
                end_pend_d = 1'b0;
              end else if (seq_bad_d) begin
                phase_d = ymfr_pkg::PH_IDLE;
                if (wr) begin
                  r1.kind   = ymfr_pkg::KIND_END;
                  r1.data   = 8'h00;
                  r1.status = ymfr_pkg::ST_BAD;
                end else begin
                  r0.kind   = ymfr_pkg::KIND_END;
                  r0.data   = 8'h00;
                  r0.status = ymfr_pkg::ST_BAD;
                end
              end
            end else if (pkt_d == ymfr_pkg::PK_EOT) begin
              r0.kind = ymfr_pkg::KIND_TX;
              if (!end_pend_q) begin
                end_pend_d = 1'b1;
                r0.data    = ymfr_pkg::CH_NAK;
                n_res      = 2'd1;
              end else begin
                r0.data = ymfr_pkg::CH_ACK;
                r1.kind = ymfr_pkg::KIND_TX;
                r1.data = ymfr_pkg::CH_C;
                n_res   = 2'd2;
              end
            end
            pos_d    = '0;
            pkt_d    = ymfr_pkg::PK_NONE;
            field_d  = ymfr_pkg::HF_NAME;
            digits_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ymfr_pkg::PH_IDLE;
      pkt_q       <= ymfr_pkg::PK_NONE;
      field_q     <= ymfr_pkg::HF_NAME;
      pos_q       <= '0;
      seq_q       <= '0;
      seq_bad_q   <= 1'b0;
      end_pend_q  <= 1'b0;
      digits_q    <= '0;
      size_q      <= '0;
      wcount_q    <= '0;
      hdr_empty_q <= 1'b1;
    end else if (accept) begin
      phase_q     <= phase_d;
      pkt_q       <= pkt_d;
      field_q     <= field_d;
      pos_q       <= pos_d;
      seq_q       <= seq_d;
      seq_bad_q   <= seq_bad_d;
      end_pend_q  <= end_pend_d;
      digits_q    <= digits_d;
      size_q      <= size_d;
      wcount_q    <= wcount_d;
      hdr_empty_q <= hdr_empty_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ymfr_back.sv =====
// Back of the Ymodem receiver: pops step records and presents their one or
// two results on a registered output. Depends on ymfr_pkg.
`default_nettype none
module ymfr_back #(
  parameter int ADDR_WIDTH = ymfr_pkg::ADDR_WIDTH_DEF,
  parameter int ENTRY_W    = 2 * ymfr_pkg::RES_W + 2 * ADDR_WIDTH + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [ENTRY_W-1:0]    entry_i,
  input  wire ymfr_pkg::q_stat_t     q_stat_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output ymfr_pkg::kind_e            kind_o,
  output logic [7:0]                 data_o,
  output logic [ADDR_WIDTH-1:0]      addr_o,
  output ymfr_pkg::status_e          status_o,
  output logic [ADDR_WIDTH:0]        len_o,
  output logic                       last_o
);

  logic                  two;
  ymfr_pkg::res_t        r0, r1, res;
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH:0]   len;
  logic                  load, take;
  logic                  valid_q, valid_d;
  logic                  second_q, second_d;
  ymfr_pkg::kind_e       kind_q;
  ymfr_pkg::status_e     status_q;
  logic [7:0]            data_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH:0]   len_q;
  logic                  last_q;

  assign {len, addr, r1, r0, two} = entry_i;

  // the output register frees when empty or taken
  assign load = !valid_q || ready_i;
  assign take = load && !q_stat_i.empty;
  assign res  = second_q ? r1 : r0;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (take) begin
        if (second_q || !two) begin
          pop_o    = 1'b1;
          second_d = 1'b0;
        end else begin
          second_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= res.kind;
      data_q   <= res.data;
      status_q <= res.status;
      addr_q   <= second_q ? '0 : addr;
      len_q    <= len;
      last_q   <= second_q || !two;
    end
  end

  assign valid_o  = valid_q;
  assign kind_o   = kind_q;
  assign data_o   = data_q;
  assign addr_o   = addr_q;
  assign status_o = status_q;
  assign len_o    = len_q;
  assign last_o   = last_q;

endmodule
`default_nettype wire

// ===== sv/ymodem_file_receiver_core.sv =====
// Ymodem file receiver core: one item in per cycle while the queue is not full;
// results pass through the queue and the registered output of the back. A step
// with two results holds the output for both of its results, and a four-record
// queue between the session front and the output back absorbs the difference.
// Reset (asynchronous, active low) puts the session idle with an empty queue.
// Depends on ymfr_pkg, ymfr_front, ymfr_fifo and ymfr_back.
`default_nettype none
module ymodem_file_receiver_core #(
  parameter int ADDR_WIDTH  = ymfr_pkg::ADDR_WIDTH_DEF,
  parameter int SIZE_DIGITS = ymfr_pkg::SIZE_DIGITS_DEF,
  parameter int NAME_LIMIT  = ymfr_pkg::NAME_LIMIT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
  input  wire logic        s_axis_tlast,   // burst_end
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // data_byte, address, status, file_length from bit 0 up, zero padded
  output logic [((2*ADDR_WIDTH+11+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last result of the item
);

  localparam int ENTRY_W = 2 * ymfr_pkg::RES_W + 2 * ADDR_WIDTH + 2;
  localparam int USED_W  = 2 * ADDR_WIDTH + 11;
  localparam int TD_W    = ((USED_W + 7) / 8) * 8;

  logic [ENTRY_W-1:0]    push_entry, head_entry;
  logic                  push, pop;
  ymfr_pkg::q_stat_t     q_stat;
  ymfr_pkg::kind_e       kind;
  ymfr_pkg::status_e     status;
  logic [7:0]            data_byte;
  logic [ADDR_WIDTH-1:0] address;
  logic [ADDR_WIDTH:0]   file_length;

  // Front: decode bytes, track the session, build one record per step
  ymfr_front #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .SIZE_DIGITS (SIZE_DIGITS),
    .NAME_LIMIT  (NAME_LIMIT),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .op_i        (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .burst_end_i (s_axis_tlast),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Queue: hold records until the output side is free
  ymfr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (ymfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (head_entry),
    .stat_o (q_stat)
  );

  // Back: advance through each record one result per cycle while the output is taken
  ymfr_back #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (head_entry),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .kind_o   (kind),
    .data_o   (data_byte),
    .addr_o   (address),
    .status_o (status),
    .len_o    (file_length),
    .last_o   (m_axis_tlast)
  );

  // Pack the result fields, first field lowest
  assign m_axis_tdata = {{(TD_W - USED_W){1'b0}}, file_length, status, address, data_byte};
  assign m_axis_tuser = kind;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ymodem_file_receiver_core: drives Ymodem sessions
// as streamed bytes and checks every result item against a built-in predictor.
// Depends on ymfr_pkg and the core with its submodules.
`timescale 1ns / 100ps
module testbench;
  import ymfr_pkg::*;

  localparam int AW          = ADDR_WIDTH_DEF;
  localparam int TD_W        = ((2*AW+11+7)/8)*8;
  localparam int NAME_LIM    = NAME_LIMIT_DEF;
  localparam int SIZE_DIG    = SIZE_DIGITS_DEF;
  localparam logic [63:0] MEM_SIZE = 64'd1 << AW;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 1700;
  localparam int CYCLE_LIMIT = 900000;

  // One result item as the core should deliver it
  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [AW-1:0] addr;
    status_e     status;
    logic [AW:0] flen;
    logic        last;
  } ym_result_t;

  // Session tracker: mirrors the receiver state and holds the awaited results
  class ymodem_rx_tracker;
    phase_e      ph;
    logic [10:0] pos;
    pkt_e        pkind;
    logic [7:0]  seq;
    bit          seq_bad;
    bit          end_pend;
    field_e      hfield;
    int unsigned digits;
    logic [AW:0] fsize;
    logic [AW:0] wr_count;
    bit          hdr_empty;
    ym_result_t  batch[$];
    ym_result_t  awaited[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      ph = PH_IDLE;
      clear_session();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_session();
      pos = '0;
      pkind = PK_NONE;
      seq = '0;
      seq_bad = 1'b0;
      end_pend = 1'b0;
      hfield = HF_NAME;
      digits = 0;
      fsize = '0;
      wr_count = '0;
      hdr_empty = 1'b1;
    endfunction

    function void add(kind_e k, logic [7:0] dat, logic [AW-1:0] a, status_e s);
      ym_result_t r;
      r.kind = k;
      r.data = dat;
      r.addr = a;
      r.status = s;
      r.flen = fsize;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    // Walk the header payload: name, optional skipped byte, then decimal size
    function void parse_header(int unsigned d, logic [7:0] b);
      logic [63:0] grown;
      if (d == 0) hdr_empty = (b == 8'h00);
      case (hfield)
        HF_NAME: begin
          if (b == 8'h00) hfield = HF_SIZE;
          else if (d + 1 >= NAME_LIM) hfield = HF_SKIP;
        end
        HF_SKIP: hfield = HF_SIZE;
        HF_SIZE: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            grown = 64'(fsize) * 64'd10 + 64'(b - CH_ZERO);
            if (grown > MEM_SIZE) grown = MEM_SIZE;
            fsize = grown[AW:0];
            digits = digits + 1;
            if (digits >= SIZE_DIG) hfield = HF_DONE;
          end else begin
            hfield = HF_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the session by one accepted item and queue what it causes
    function void absorb_item(logic [1:0] op, logic [7:0] b, logic be);
      int unsigned d;
      int unsigned lim;
      batch.delete();
      if (op == OP_START) begin
        clear_session();
        ph = PH_HEADER;
        add(KIND_TX, CH_C, '0, ST_OK);
      end else if (op == OP_TIMEOUT) begin
        if (ph == PH_HEADER) begin
          if (pos != 0) add(KIND_END, 8'h00, '0, ST_BAD);
          else add(KIND_END, 8'h00, '0, ST_TIMEOUT);
        end else if (ph == PH_DATA) begin
          add(KIND_END, 8'h00, '0, ST_OK);
        end
        ph = PH_IDLE;
        pos = '0;
      end else if (op == OP_BYTE && ph != PH_IDLE) begin
        if (pos == 0) begin
          if (b == CH_SOH) pkind = PK_SOH;
          else if (b == CH_STX) pkind = PK_STX;
          else if (b == CH_EOT) pkind = PK_EOT;
          else pkind = PK_NONE;
          seq_bad = 1'b1;
        end else if (pos == 1) begin
          seq = b;
        end else if (pos == 2) begin
          seq_bad = ((seq ^ b) != SEQ_CMPL);
        end else begin
          d = 32'(pos) - 3;
          if (ph == PH_HEADER) begin
            if (d < 32'(HDR_PAYLOAD)) parse_header(d, b);
          end else begin
            lim = (pkind == PK_SOH) ? 32'(SOH_PAYLOAD) : 32'(STX_PAYLOAD);
            if ((pkind == PK_SOH || pkind == PK_STX) && !end_pend && !seq_bad &&
                d < lim && wr_count < fsize) begin
              add(KIND_WRITE, b, wr_count[AW-1:0], ST_OK);
              wr_count = wr_count + 1'b1;
            end
          end
        end
        if (pos < POS_MAX) pos = pos + 1'b1;

        if (be) begin
          if (ph == PH_HEADER) begin
            if (pos != HEADER_LEN || seq_bad) begin
              add(KIND_END, 8'h00, '0, ST_BAD);
              ph = PH_IDLE;
            end else begin
              // an empty name means no file: answer ACK only, size forced to zero
              if (hdr_empty) fsize = '0;
              add(KIND_TX, CH_ACK, '0, ST_OK);
              if (!hdr_empty) add(KIND_TX, CH_C, '0, ST_OK);
              wr_count = '0;
              end_pend = 1'b0;
              ph = PH_DATA;
            end
          end else if (pkind == PK_SOH || pkind == PK_STX) begin
            if (end_pend) begin
              end_pend = 1'b0;
              add(KIND_TX, CH_ACK, '0, ST_OK);
            end else if (seq_bad) begin
              add(KIND_END, 8'h00, '0, ST_BAD);
              ph = PH_IDLE;
            end else begin
              add(KIND_TX, CH_ACK, '0, ST_OK);
            end
          end else if (pkind == PK_EOT) begin
            if (!end_pend) begin
              end_pend = 1'b1;
              add(KIND_TX, CH_NAK, '0, ST_OK);
            end else begin
              add(KIND_TX, CH_ACK, '0, ST_OK);
              add(KIND_TX, CH_C, '0, ST_OK);
            end
          end
          pos = '0;
          pkind = PK_NONE;
          hfield = HF_NAME;
          digits = 0;
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) awaited.push_back(batch[i]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_result(logic [TD_W-1:0] td, logic [1:0] user, logic lst);
      ym_result_t e;
      logic [TD_W-1:0] want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result kind %0d tdata %h last %b", user, td, lst));
        return;
      end
      e = awaited.pop_front();
      want = '0;
      want[7:0] = e.data;
      want[8 +: AW] = e.addr;
      want[8+AW +: 2] = e.status;
      want[10+AW +: AW+1] = e.flen;
      if (user !== e.kind || td !== want || lst !== e.last)
        report($sformatf({"result %0d: got kind %0d data %h addr %h st %0d len %0d pad %h",
                          " last %b / want kind %0d data %h addr %h st %0d len %0d last %b"},
                         checked, user, td[7:0], td[8 +: AW], td[8+AW +: 2],
                         td[10+AW +: AW+1], td[TD_W-1:2*AW+11], lst,
                         e.kind, e.data, e.addr, e.status, e.flen, e.last));
      checked++;
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]      s_axis_tuser;   // [1:0] operation
  logic            s_axis_tlast;   // burst_end
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [TD_W-1:0] m_axis_tdata;   // data_byte, address, status, file_length, zero pad
  logic [1:0]      m_axis_tuser;   // [1:0] kind
  logic            m_axis_tlast;   // last result of the item

  ymodem_file_receiver_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ymodem_rx_tracker trk;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned rand_base;
  bit          rand_part;
  int unsigned cycle_count;
  logic [7:0]  burst_q[$];

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Note accepted items and check accepted results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      trk.absorb_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      trk.compare_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Present one item from a falling edge and hold it until accepted;
  // return at the next falling edge with tvalid still high.
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic be);
    int unsigned mix;
    if (rand_part) begin
      mix = (items_sent - rand_base) * 4 / RAND_ITEMS;
      case (mix)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 74; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= be;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Send the queued packet, burst_end on its last byte; a cut packet stops
  // early and the session is ended by a timeout instead.
  task automatic send_burst(bit cut);
    int unsigned stop;
    stop = cut ? $urandom_range(burst_q.size() - 1) : burst_q.size();
    for (int i = 0; i < stop; i++)
      send_item(OP_BYTE, burst_q[i], !cut && (i == burst_q.size() - 1));
    if (cut) send_item(OP_TIMEOUT, 8'($urandom), 1'($urandom));
  endtask

  // Header packet: name, terminator, decimal size; sometimes malformed
  task automatic send_header();
    logic [7:0]  body [128];
    string       size_txt;
    int unsigned pick;
    int unsigned name_len;
    int unsigned at;
    logic [7:0]  sq;
    logic [7:0]  comp;
    bit          junk;
    junk = ($urandom_range(3) == 0);
    for (int i = 0; i < 128; i++) body[i] = junk ? 8'($urandom) : 8'h00;
    pick = $urandom_range(5);
    if (pick == 0) begin
      // empty name: file size is dropped
      body[0] = 8'h00;
      at = 1;
    end else if (pick == 1) begin
      // name hits the length limit, the following byte is skipped
      for (int i = 0; i < NAME_LIM; i++) body[i] = 8'($urandom_range(1, 255));
      body[NAME_LIM] = 8'($urandom);
      at = NAME_LIM + 1;
    end else begin
      name_len = $urandom_range(1, 20);
      for (int i = 0; i < name_len; i++) body[i] = 8'($urandom_range(1, 255));
      body[name_len] = 8'h00;
      at = name_len + 1;
    end
    pick = $urandom_range(9);
    case (pick)
      0:       size_txt = ($urandom_range(1) == 0) ? "99999999" : "1048576";
      1:       size_txt = "12345678901234567";
      2:       size_txt = {"-", $sformatf("%0d", $urandom_range(999))};
      3:       size_txt = {" ", $sformatf("%0d", $urandom_range(999))};
      default: size_txt = $sformatf("%0d", $urandom_range(400));
    endcase
    for (int i = 0; i < size_txt.len() && at < 128; i++) begin
      body[at] = size_txt[i];
      at++;
    end
    if (at < 128) body[at] = ($urandom_range(1) == 0) ? 8'h20 : 8'h00;

    sq = 8'($urandom);
    comp = ~sq;
    pick = $urandom_range(11);
    if (pick == 0) comp = comp ^ 8'($urandom_range(1, 255));
    burst_q.delete();
    burst_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : CH_SOH);
    burst_q.push_back(sq);
    burst_q.push_back(comp);
    for (int i = 0; i < 128; i++) burst_q.push_back(body[i]);
    burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
    // wrong length: one byte short, one too many, or cut well short
    if (pick == 1) void'(burst_q.pop_back());
    else if (pick == 2) burst_q.push_back(8'($urandom));
    else if (pick == 3) begin
      at = $urandom_range(1, 130);
      while (burst_q.size() > at) void'(burst_q.pop_back());
    end
    send_burst($urandom_range(19) == 0);
  endtask

  // Data packet: mostly SOH with random payload, some STX, some broken
  task automatic send_data_packet();
    int unsigned pick;
    int unsigned plen;
    int unsigned keep;
    logic [7:0]  kb;
    logic [7:0]  sq;
    pick = $urandom_range(19);
    kb = CH_SOH;
    plen = 128;
    if (pick == 14 || pick == 15) begin
      kb = CH_STX;
      plen = 1024;
    end else if (pick == 16) begin
      kb = 8'($urandom);
      if (kb == CH_SOH || kb == CH_STX || kb == CH_EOT) kb = 8'h00;
    end else if (pick == 19) begin
      plen = $urandom_range(0, 140);
    end
    sq = 8'($urandom);
    burst_q.delete();
    burst_q.push_back(kb);
    burst_q.push_back(sq);
    burst_q.push_back((pick == 18) ? (~sq ^ 8'($urandom_range(1, 255))) : ~sq);
    for (int i = 0; i < plen; i++) burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
    // short packet: ends before the sequence complement
    if (pick == 17) begin
      keep = $urandom_range(1, 2);
      while (burst_q.size() > keep) void'(burst_q.pop_back());
    end
    send_burst($urandom_range(15) == 0);
  endtask

  task automatic send_eot();
    burst_q.delete();
    burst_q.push_back(CH_EOT);
    send_burst(1'b0);
  endtask

  // One session: start, header, a few data packets, EOT pair, end
  task automatic run_session();
    int unsigned npkt;
    send_item(OP_START, 8'($urandom), 1'($urandom));
    if ($urandom_range(11) == 0) begin
      send_item(OP_TIMEOUT, 8'($urandom), 1'($urandom));
      return;
    end
    send_header();
    if (trk.ph == PH_DATA) begin
      npkt = $urandom_range(1, 3);
      repeat (npkt) if (trk.ph == PH_DATA) send_data_packet();
      if (trk.ph == PH_DATA) send_eot();
      // a data packet between the two EOTs is answered with ACK alone
      if (trk.ph == PH_DATA && $urandom_range(4) == 0) send_data_packet();
      if (trk.ph == PH_DATA) send_eot();
      if (trk.ph == PH_DATA && $urandom_range(2) == 0) send_data_packet();
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 12))
        send_item(2'($urandom_range(3)), 8'($urandom), ($urandom_range(3) == 0));
    end
    if ($urandom_range(5) == 0) send_item(OP_START, 8'($urandom), 1'($urandom));
    else send_item(OP_TIMEOUT, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = OP_BYTE;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;
    rand_base     = 0;
    rand_part     = 1'b0;
    cycle_count   = 0;
    trk = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Bytes, timeouts and the unused code while idle: no result
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hff, 1'b1);
    send_item(OP_TIMEOUT, 8'h00, 1'b0);
    send_item(OP_UNUSED, 8'haa, 1'b1);
    // Timeout before any header byte, then after one
    send_item(OP_START, 8'h00, 1'b0);
    send_item(OP_TIMEOUT, 8'h00, 1'b0);
    send_item(OP_START, 8'hff, 1'b1);
    send_item(OP_BYTE, CH_SOH, 1'b0);
    send_item(OP_TIMEOUT, 8'hff, 1'b1);
    // Restart, then a header cut after the sequence bytes
    send_item(OP_START, 8'h00, 1'b0);
    send_item(OP_START, 8'h00, 1'b0);
    send_item(OP_BYTE, CH_SOH, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hff, 1'b1);
    // One-byte packet in the header phase
    send_item(OP_START, 8'h00, 1'b0);
    send_item(OP_BYTE, CH_STX, 1'b1);
    // Unused code during a session is ignored
    send_item(OP_START, 8'h00, 1'b0);
    send_item(OP_UNUSED, 8'h55, 1'b1);
    send_item(OP_TIMEOUT, 8'h00, 1'b0);

    rand_part = 1'b1;
    rand_base = items_sent;
    while (items_sent - rand_base < RAND_ITEMS) run_session();

    s_axis_tvalid <= 1'b0;
    while (trk.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (trk.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
